// ----- rtl/core/smcr_pkg.sv -----
package smcr_pkg;

   // Command bytes received from the master while idle.
   localparam logic [7:0] CMD_HANDSHAKE = 8'b1010_0010;
   localparam logic [7:0] CMD_RAW       = 8'b1010_0111;
   localparam logic [7:0] CMD_WATTS     = 8'b1010_1011;
   localparam logic [7:0] CMD_PFACTOR   = 8'b1010_1110;
   localparam logic [7:0] CMD_CAL_READ  = 8'b1011_0011;
   localparam logic [7:0] CMD_CAL_WRITE = 8'b1011_0110;

   // Reply and store constants.
   localparam logic [7:0] REPLY_CAL_OK    = 8'b1010_1010;
   localparam logic [7:0] REPLY_ZERO      = 8'h00;
   localparam logic [7:0] CAL_MARKER      = 8'hCA;
   localparam logic [7:0] STATUS_BASE     = 8'b1000_0000;
   localparam logic [9:0] SENSE_FULL      = 10'd1023;

   localparam int unsigned STORE_BYTES_DEFAULT = 8;
   localparam int unsigned PEND_DEPTH          = 8;
   localparam int unsigned CAL_DATA_BYTES      = 6;

   // Status flags produced for the handshake reply.
   typedef struct packed {
      logic voltage_absent;
      logic overcurrent;
      logic high_current;
   } status_flags_type;

endpackage

// ----- rtl/core/smcr_status_flags.sv -----
module smcr_status_flags (
   input  logic [9:0]                  voltage_peak,
   input  logic [9:0]                  voltage_trough,
   input  logic [9:0]                  sense_peak,
   input  logic                        range_mode,
   input  logic signed [8:0]           voltage_gain,
   output smcr_pkg::status_flags_type  flags
);
   import smcr_pkg::*;

   logic signed [11:0] swing;
   logic signed [11:0] scale;
   logic signed [11:0] bound;

   // The swing may be negative when the trough sits above the peak.
   // The bound is twice the scale and never exceeds 1022.
   always_comb begin
      swing = $signed({2'b00, voltage_peak}) - $signed({2'b00, voltage_trough});
      scale = $signed({{3{voltage_gain[8]}}, voltage_gain}) + 12'sd256;
      bound = scale <<< 1;
      flags.voltage_absent = swing < bound;
      flags.overcurrent    = sense_peak == SENSE_FULL;
      flags.high_current   = !range_mode;
   end

endmodule

// ----- rtl/core/spi_meter_command_responder.sv -----
// Latency: a result is valid in the cycle after its request transfer (one register stage).
// Throughput: one request per cycle; the next request is taken while a result waits,
// as long as the result register is empty or is being drained in the same cycle.
// Each byte is decoded against the phase register and answered in one pass of logic.
// Reset (synchronous, active high) returns to idle, clears the position and the
// calibration store, and drops rsp_valid.
module spi_meter_command_responder #(
   parameter int unsigned STORE_BYTES = smcr_pkg::STORE_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_rx_byte,
   input  logic [15:0]       req_current_sample,
   input  logic [15:0]       req_voltage_sample,
   input  logic [15:0]       req_watts_value,
   input  logic [9:0]        req_voltage_peak,
   input  logic [9:0]        req_voltage_trough,
   input  logic [9:0]        req_sense_peak,
   input  logic              req_range_mode,
   input  logic signed [8:0] req_voltage_gain,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_reply_byte,
   output logic              rsp_led_on,
   output logic              rsp_calibration_stored,
   output logic              rsp_checksum_failed
);
   import smcr_pkg::*;

   localparam int unsigned POS_W = $clog2(PEND_DEPTH);
   localparam logic [POS_W-1:0] RAW_LAST       = POS_W'(2);
   localparam logic [POS_W-1:0] CAL_READ_LAST  = POS_W'(5);
   localparam logic [POS_W-1:0] CAL_WRITE_DONE = POS_W'(7);

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_RAW       = 3'd1,
      PH_WATTS     = 3'd2,
      PH_CAL_READ  = 3'd3,
      PH_CAL_WRITE = 3'd4
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [POS_W-1:0]   position_ff, position_in, pos_next;
   logic [7:0]         pending_ff [PEND_DEPTH];
   logic [7:0]         pending_in [PEND_DEPTH];
   logic [7:0]         store_ff [STORE_BYTES];
   logic [7:0]         store_in [STORE_BYTES];

   logic               rsp_valid_ff;
   logic [7:0]         reply_ff, reply_in;
   logic               led_ff, led_in;
   logic               stored_ff, stored_in;
   logic               failed_ff, failed_in;

   logic               accept;
   logic [7:0]         store_sum;
   logic [7:0]         pending_sum;
   status_flags_type   flags;

   smcr_status_flags u_flags (
      .voltage_peak   (req_voltage_peak),
      .voltage_trough (req_voltage_trough),
      .sense_peak     (req_sense_peak),
      .range_mode     (req_range_mode),
      .voltage_gain   (req_voltage_gain),
      .flags          (flags)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Checksums over the six calibration data bytes.
   always_comb begin
      store_sum   = '0;
      pending_sum = '0;
      for (int i = 0; i < CAL_DATA_BYTES; i++) begin
         store_sum   = store_sum + store_ff[i + 1];
         pending_sum = pending_sum + pending_ff[i];
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      position_in = position_ff;
      pending_in  = pending_ff;
      store_in    = store_ff;
      reply_in    = req_rx_byte;
      stored_in   = 1'b0;
      failed_in   = 1'b0;
      pos_next    = position_ff + 1'b1;
      led_in      = 1'b1;

      unique case (phase_ff)
         PH_RAW: begin
            reply_in    = pending_ff[position_ff];
            position_in = pos_next;
            if (pos_next > RAW_LAST) begin
               phase_in = PH_IDLE;
            end
         end
         PH_WATTS: begin
            reply_in = pending_ff[0];
            phase_in = PH_IDLE;
         end
         PH_CAL_READ: begin
            reply_in    = pending_ff[position_ff];
            position_in = pos_next;
            if (pos_next > CAL_READ_LAST) begin
               phase_in = PH_IDLE;
            end
         end
         PH_CAL_WRITE: begin
            pending_in[position_ff] = req_rx_byte;
            position_in             = pos_next;
            // The seventh byte is the checksum; the first six are already held.
            if (pos_next == CAL_WRITE_DONE) begin
               phase_in = PH_IDLE;
               if (pending_sum != req_rx_byte) begin
                  reply_in  = REPLY_ZERO;
                  failed_in = 1'b1;
               end else begin
                  for (int i = 0; i < CAL_DATA_BYTES; i++) begin
                     store_in[i + 1] = pending_ff[i];
                  end
                  store_in[0] = CAL_MARKER;
                  reply_in    = REPLY_CAL_OK;
                  stored_in   = 1'b1;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
            led_in   = req_rx_byte != '0;
            unique case (req_rx_byte)
               CMD_HANDSHAKE: begin
                  reply_in = STATUS_BASE | {4'b0000, flags.voltage_absent, flags.overcurrent,
                                            flags.high_current, 1'b0};
               end
               CMD_RAW: begin
                  reply_in      = req_current_sample[15:8];
                  pending_in[0] = req_current_sample[7:0];
                  pending_in[1] = req_voltage_sample[15:8];
                  pending_in[2] = req_voltage_sample[7:0];
                  phase_in      = PH_RAW;
                  position_in   = '0;
               end
               CMD_WATTS: begin
                  reply_in      = req_watts_value[15:8];
                  pending_in[0] = req_watts_value[7:0];
                  phase_in      = PH_WATTS;
               end
               CMD_PFACTOR: begin
                  reply_in = REPLY_ZERO;
               end
               CMD_CAL_READ: begin
                  reply_in = store_ff[1];
                  for (int i = 0; i < CAL_DATA_BYTES - 1; i++) begin
                     pending_in[i] = store_ff[i + 2];
                  end
                  pending_in[CAL_DATA_BYTES - 1] = store_sum;
                  phase_in    = PH_CAL_READ;
                  position_in = '0;
               end
               CMD_CAL_WRITE: begin
                  phase_in    = PH_CAL_WRITE;
                  position_in = '0;
               end
               default: begin
                  reply_in = req_rx_byte;
               end
            endcase
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         position_ff  <= '0;
         store_ff     <= '{default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            position_ff  <= position_in;
            store_ff     <= store_in;
            pending_ff   <= pending_in;
            reply_ff     <= reply_in;
            led_ff       <= led_in;
            stored_ff    <= stored_in;
            failed_ff    <= failed_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_reply_byte         = reply_ff;
   assign rsp_led_on             = led_ff;
   assign rsp_calibration_stored = stored_ff;
   assign rsp_checksum_failed    = failed_ff;

endmodule

// ----- rtl/core/smcr_checker.sv -----
module smcr_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_reply_byte,
   input logic       rsp_led_on,
   input logic       rsp_calibration_stored,
   input logic       rsp_checksum_failed
);
   import smcr_pkg::*;

   // A stalled result transfer keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_reply_byte)
         && $stable(rsp_calibration_stored) && $stable(rsp_checksum_failed))
      else $error("result changed while stalled");

   // A calibration write ends either stored or failed, never both.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_calibration_stored && rsp_checksum_failed))
      else $error("stored and failed pulses together");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_calibration_stored |-> rsp_reply_byte == REPLY_CAL_OK && rsp_led_on)
      else $error("stored calibration without acknowledge reply");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_checksum_failed |-> rsp_reply_byte == REPLY_ZERO && rsp_led_on)
      else $error("checksum failure without zero reply");

endmodule

bind spi_meter_command_responder smcr_checker u_smcr_checker (
   .clock                  (clock),
   .reset                  (reset),
   .rsp_valid              (rsp_valid),
   .rsp_ready              (rsp_ready),
   .rsp_reply_byte         (rsp_reply_byte),
   .rsp_led_on             (rsp_led_on),
   .rsp_calibration_stored (rsp_calibration_stored),
   .rsp_checksum_failed    (rsp_checksum_failed)
);

// ----- sim/spi_meter_command_responder_test.sv -----
module spi_meter_command_responder_test;
   timeunit 1ns;
   timeprecision 1ps;

   import smcr_pkg::*;

   localparam int unsigned CAL_STORE_BYTES = STORE_BYTES_DEFAULT;
   localparam int DIRECTED_COUNT = 26;
   localparam int RANDOM_ITEMS   = 1550;
   localparam int HOLD_CYCLES    = 200;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int PRINT_LIMIT    = 30;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_RAW,
      PH_WATTS,
      PH_CAL_READ,
      PH_CAL_WRITE
   } meter_phase_type;

   typedef struct {
      logic [7:0]        rx;
      logic [15:0]       cur;
      logic [15:0]       volt;
      logic [15:0]       watts;
      logic [9:0]        vpeak;
      logic [9:0]        vtrough;
      logic [9:0]        speak;
      logic              mode;
      logic signed [8:0] gain;
   } meter_req_type;

   typedef struct {
      logic [7:0] reply;
      logic       led;
      logic       stored;
      logic       failed;
   } meter_rsp_type;

   typedef struct {
      meter_req_type req;
      bit            typed;
      meter_rsp_type want;
   } meter_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [7:0]        req_rx_byte = '0;
   logic [15:0]       req_current_sample = '0;
   logic [15:0]       req_voltage_sample = '0;
   logic [15:0]       req_watts_value = '0;
   logic [9:0]        req_voltage_peak = '0;
   logic [9:0]        req_voltage_trough = '0;
   logic [9:0]        req_sense_peak = '0;
   logic              req_range_mode = 1'b0;
   logic signed [8:0] req_voltage_gain = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [7:0]        rsp_reply_byte;
   logic              rsp_led_on;
   logic              rsp_calibration_stored;
   logic              rsp_checksum_failed;

   spi_meter_command_responder #(.STORE_BYTES(CAL_STORE_BYTES)) i_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Mirror of the responder state.
   meter_phase_type meter_phase = PH_IDLE;
   logic [2:0]      meter_pos = '0;
   logic [7:0]      pending [PEND_DEPTH] = '{default: '0};
   logic [7:0]      cal_store [CAL_STORE_BYTES] = '{default: '0};

   meter_rsp_type expected_replies [$];
   int            mismatch_count = 0;
   int            cycle_count = 0;
   int            items_accepted = 0;
   int            stall_left = 0;
   bit            hold_off = 1'b0;
   bit            sender_steady = 1'b0;
   bit            receiver_steady = 1'b0;

   logic [7:0] command_set [6] = '{CMD_HANDSHAKE, CMD_RAW, CMD_WATTS, CMD_PFACTOR,
                                   CMD_CAL_READ, CMD_CAL_WRITE};

   meter_row_type directed_rows [DIRECTED_COUNT] = '{
      // An idle zero byte is echoed with the LED off; an unknown byte lights it.
      '{'{8'h00, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0, 1'b1, 9'sd0},
        1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
      '{'{8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd1023, 10'd1023, 10'd1023, 1'b1, 9'sd0},
        1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0}},
      // Handshake with every status flag set, then with none.
      '{'{CMD_HANDSHAKE, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd1023, SENSE_FULL, 1'b0,
          9'sd255}, 1'b1, '{8'h8E, 1'b1, 1'b0, 1'b0}},
      '{'{CMD_HANDSHAKE, 16'h0000, 16'h0000, 16'h0000, 10'd1023, 10'd0, 10'd1022, 1'b1,
          -9'sd255}, 1'b1, '{STATUS_BASE, 1'b1, 1'b0, 1'b0}},
      '{'{CMD_PFACTOR, 16'h1234, 16'h5678, 16'h9ABC, 10'd5, 10'd5, 10'd5, 1'b0, 9'sd0},
        1'b1, '{REPLY_ZERO, 1'b1, 1'b0, 1'b0}},
      // Raw read; the three snapshot bytes follow whatever the master sends.
      '{'{CMD_RAW, 16'hFFFF, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0, 1'b1, 9'sd0},
        1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
      '{'{8'h00, 16'h0000, 16'hFFFF, 16'h0000, 10'd0, 10'd0, 10'd0, 1'b1, 9'sd0},
        1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
      '{'{CMD_RAW, 16'h0000, 16'hFFFF, 16'h0000, 10'd0, 10'd0, 10'd0, 1'b1, 9'sd0},
        1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
      '{'{8'hFF, 16'h0000, 16'hFFFF, 16'h0000, 10'd0, 10'd0, 10'd0, 1'b1, 9'sd0},
        1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
      '{'{CMD_WATTS, 16'h0000, 16'h0000, 16'hFFFF, 10'd0, 10'd0, 10'd0, 1'b1, 9'sd0},
        1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
      '{'{CMD_WATTS, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0, 1'b1, 9'sd0},
        1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
      // Calibration read of the blank store: all six bytes and the sum are zero.
      '{'{CMD_CAL_READ, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0, 1'b1, 9'sd0},
        1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
      '{'{8'h55, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0, 1'b1, 9'sd0},
        1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
      '{'{8'hAA, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0, 1'b1, 9'sd0},
        1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
      '{'{CMD_CAL_WRITE, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0, 1'b1, 9'sd0},
        1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
      '{'{8'h00, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0, 1'b1, 9'sd0},
        1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
      '{'{8'hFF, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0, 1'b1, 9'sd0},
        1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
      '{'{8'h01, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0, 1'b1, 9'sd0},
        1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
      // Calibration write: data bytes are echoed, then a bad checksum is refused.
      '{'{CMD_CAL_WRITE, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0, 1'b1, 9'sd0},
        1'b1, '{CMD_CAL_WRITE, 1'b1, 1'b0, 1'b0}},
      '{'{8'h01, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0, 1'b1, 9'sd0},
        1'b1, '{8'h01, 1'b1, 1'b0, 1'b0}},
      '{'{8'h02, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0, 1'b1, 9'sd0},
        1'b1, '{8'h02, 1'b1, 1'b0, 1'b0}},
      '{'{8'h03, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0, 1'b1, 9'sd0},
        1'b1, '{8'h03, 1'b1, 1'b0, 1'b0}},
      '{'{8'h04, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0, 1'b1, 9'sd0},
        1'b1, '{8'h04, 1'b1, 1'b0, 1'b0}},
      '{'{8'h05, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0, 1'b1, 9'sd0},
        1'b1, '{8'h05, 1'b1, 1'b0, 1'b0}},
      '{'{8'h06, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0, 1'b1, 9'sd0},
        1'b1, '{8'h06, 1'b1, 1'b0, 1'b0}},
      '{'{8'h00, 16'h0000, 16'h0000, 16'h0000, 10'd0, 10'd0, 10'd0, 1'b1, 9'sd0},
        1'b1, '{REPLY_ZERO, 1'b1, 1'b0, 1'b1}}
   };

   function automatic int draw_wait(input bit steady);
      return steady ? 0 : int'($urandom_range(0, 15));
   endfunction

   function automatic meter_rsp_type predict_reply(input meter_req_type r);
      meter_rsp_type    o;
      status_flags_type flags;
      logic [7:0]       sum;
      int               i;
      o = '{r.rx, 1'b1, 1'b0, 1'b0};
      case (meter_phase)
         PH_RAW: begin
            o.reply = pending[meter_pos];
            meter_pos = meter_pos + 3'd1;
            if (meter_pos > 3'd2) meter_phase = PH_IDLE;
         end
         PH_WATTS: begin
            o.reply = pending[0];
            meter_phase = PH_IDLE;
         end
         PH_CAL_READ: begin
            o.reply = pending[meter_pos];
            meter_pos = meter_pos + 3'd1;
            if (meter_pos > 3'd5) meter_phase = PH_IDLE;
         end
         PH_CAL_WRITE: begin
            pending[meter_pos] = r.rx;
            meter_pos = meter_pos + 3'd1;
            if (meter_pos == 3'd7) begin
               meter_phase = PH_IDLE;
               sum = '0;
               for (i = 0; i < CAL_DATA_BYTES; i++) sum = sum + pending[i];
               if (sum != pending[CAL_DATA_BYTES]) begin
                  o.reply = REPLY_ZERO;
                  o.failed = 1'b1;
               end else begin
                  for (i = 0; i < CAL_DATA_BYTES; i++) cal_store[i + 1] = pending[i];
                  cal_store[0] = CAL_MARKER;
                  o.reply = REPLY_CAL_OK;
                  o.stored = 1'b1;
               end
            end
         end
         default: begin
            meter_phase = PH_IDLE;
            o.led = (r.rx != 8'h00);
            case (r.rx)
               CMD_HANDSHAKE: begin
                  // A trough above the peak gives a negative span, which always counts.
                  flags.voltage_absent = (int'(r.vpeak) - int'(r.vtrough))
                                         < 2 * (256 + int'(r.gain));
                  flags.overcurrent = (r.speak == SENSE_FULL);
                  flags.high_current = !r.mode;
                  o.reply = STATUS_BASE | {4'b0000, flags, 1'b0};
               end
               CMD_RAW: begin
                  o.reply = r.cur[15:8];
                  pending[0] = r.cur[7:0];
                  pending[1] = r.volt[15:8];
                  pending[2] = r.volt[7:0];
                  meter_phase = PH_RAW;
                  meter_pos = '0;
               end
               CMD_WATTS: begin
                  o.reply = r.watts[15:8];
                  pending[0] = r.watts[7:0];
                  meter_phase = PH_WATTS;
               end
               CMD_PFACTOR: o.reply = REPLY_ZERO;
               CMD_CAL_READ: begin
                  sum = cal_store[1];
                  o.reply = sum;
                  for (i = 0; i < CAL_DATA_BYTES - 1; i++) begin
                     pending[i] = cal_store[i + 2];
                     sum = sum + pending[i];
                  end
                  pending[CAL_DATA_BYTES - 1] = sum;
                  meter_phase = PH_CAL_READ;
                  meter_pos = '0;
               end
               CMD_CAL_WRITE: begin
                  meter_phase = PH_CAL_WRITE;
                  meter_pos = '0;
               end
               default: ;
            endcase
         end
      endcase
      return o;
   endfunction

   function automatic meter_req_type random_meter(input logic [7:0] rx);
      meter_req_type r;
      r.rx = rx;
      r.cur = 16'($urandom);
      r.volt = 16'($urandom);
      r.watts = 16'($urandom);
      r.vpeak = ($urandom_range(0, 7) == 0) ? 10'd1023 : 10'($urandom);
      r.vtrough = ($urandom_range(0, 7) == 0) ? 10'd0 : 10'($urandom);
      r.speak = ($urandom_range(0, 3) == 0) ? SENSE_FULL : 10'($urandom);
      r.mode = 1'($urandom);
      r.gain = 9'(int'($urandom_range(0, 510)) - 255);
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) $display("cycle %0d: %s", cycle_count, msg);
   endtask

   // Offers one request and records its expected reply once the transfer happens.
   task automatic offer(input meter_req_type r, input bit typed, input meter_rsp_type want);
      int            gap;
      meter_rsp_type predicted;
      if ($urandom_range(0, 29) == 0) sender_steady = !sender_steady;
      gap = draw_wait(sender_steady);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= r.rx;
      req_current_sample <= r.cur;
      req_voltage_sample <= r.volt;
      req_watts_value <= r.watts;
      req_voltage_peak <= r.vpeak;
      req_voltage_trough <= r.vtrough;
      req_sense_peak <= r.speak;
      req_range_mode <= r.mode;
      req_voltage_gain <= r.gain;
      do @(posedge clock); while (!req_ready);
      predicted = predict_reply(r);
      expected_replies.push_back(typed ? want : predicted);
      items_accepted++;
   endtask

   task automatic offer_byte(input logic [7:0] rx);
      offer(random_meter(rx), 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0});
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL spi_meter_command_responder");
         $finish;
      end
   end

   always @(posedge clock) begin : check_replies
      meter_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_replies.size() == 0) begin
            report_mismatch($sformatf("reply %h with nothing outstanding", rsp_reply_byte));
         end else begin
            want = expected_replies.pop_front();
            if (rsp_reply_byte !== want.reply)
               report_mismatch($sformatf("reply_byte %h, expected %h",
                                         rsp_reply_byte, want.reply));
            if (rsp_led_on !== want.led)
               report_mismatch($sformatf("led_on %b, expected %b", rsp_led_on, want.led));
            if (rsp_calibration_stored !== want.stored)
               report_mismatch($sformatf("calibration_stored %b, expected %b",
                                         rsp_calibration_stored, want.stored));
            if (rsp_checksum_failed !== want.failed)
               report_mismatch($sformatf("checksum_failed %b, expected %b",
                                         rsp_checksum_failed, want.failed));
         end
         if ($urandom_range(0, 29) == 0) receiver_steady = !receiver_steady;
         stall_left <= draw_wait(receiver_steady);
      end
   end

   always @(negedge clock) begin
      rsp_ready <= !(hold_off || stall_left != 0);
      if (!hold_off && stall_left != 0) stall_left <= stall_left - 1;
   end

   // Long receiver hold-off while requests keep coming, so the result stage backs up.
   initial begin
      wait (items_accepted >= 500);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin : stimulus
      int            pick;
      logic [7:0]    sum;
      logic [7:0]    data;
      meter_req_type r;
      int            bound;
      int            base;
      int            nudge;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         offer(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

      while (items_accepted < DIRECTED_COUNT + RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 38) begin
            // Calibration write, mostly with a correct checksum.
            sum = '0;
            offer_byte(CMD_CAL_WRITE);
            repeat (CAL_DATA_BYTES) begin
               data = 8'($urandom);
               sum = sum + data;
               offer_byte(data);
            end
            offer_byte((pick < 8) ? sum + 8'($urandom_range(1, 255)) : sum);
         end else if (pick < 53) begin
            offer_byte(CMD_CAL_READ);
            repeat (CAL_DATA_BYTES) offer_byte(8'($urandom));
         end else if (pick < 63) begin
            offer_byte(CMD_RAW);
            repeat (3) offer_byte(8'($urandom));
         end else if (pick < 71) begin
            offer_byte(CMD_WATTS);
            offer_byte(8'($urandom));
         end else if (pick < 82) begin
            r = random_meter(CMD_HANDSHAKE);
            if ($urandom_range(0, 1) == 1) begin
               // Put the peak-to-trough span right at the no-voltage bound.
               bound = 2 * (256 + int'(r.gain));
               base = $urandom_range(0, 1023 - bound);
               nudge = int'($urandom_range(0, 2)) - 1;
               r.vtrough = 10'(base);
               r.vpeak = 10'((base + bound + nudge > 1023) ? 1023 : base + bound + nudge);
            end
            offer(r, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0});
         end else if (pick < 86) begin
            offer_byte(CMD_PFACTOR);
         end else if (pick < 93) begin
            // A command cut short; the next sequence's bytes get swallowed.
            offer_byte(command_set[$urandom_range(0, 5)]);
            repeat ($urandom_range(0, 2)) offer_byte(8'($urandom));
         end else begin
            repeat ($urandom_range(1, 3)) offer_byte(8'($urandom));
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS spi_meter_command_responder");
      end else begin
         $display("FAIL spi_meter_command_responder");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/smcr_pkg.sv
rtl/core/smcr_status_flags.sv
rtl/core/spi_meter_command_responder.sv
rtl/core/smcr_checker.sv
sim/spi_meter_command_responder_test.sv
